FILE: rtl/lbft_pkg.sv
// lbft_pkg: shared types, formats and constants of the lidar beam transform
// no dependencies; imported by every rtl module of the block
`default_nettype none
package lbft_pkg;

  // register indexes of the configuration port
  localparam logic [3:0] REG_ROT_XX   = 4'd0;
  localparam logic [3:0] REG_ROT_XY   = 4'd1;
  localparam logic [3:0] REG_ROT_YX   = 4'd2;
  localparam logic [3:0] REG_ROT_YY   = 4'd3;
  localparam logic [3:0] REG_SHIFT_X  = 4'd4;
  localparam logic [3:0] REG_SHIFT_Y  = 4'd5;
  localparam logic [3:0] REG_START    = 4'd6;
  localparam logic [3:0] REG_STEP     = 4'd7;

  localparam int ATAN_ENTRIES = 24;
  localparam int W_C   = 34;   // sin/cos cordic datapath, q1.30 plus headroom
  localparam int W_Z   = 34;   // cordic angle, 2^32 per turn
  localparam int W_PR  = 51;   // range times cos/sin
  localparam int W_PT  = 37;   // point in mm q16
  localparam int W_RP  = 53;   // rotation coefficient times point
  localparam int W_V   = 56;   // vectoring datapath, mm q30
  localparam int W_M   = 42;   // magnitude in mm q16
  localparam int W_LO  = 20;   // low part of magnitude for the split multiply
  localparam int W_HI  = W_M - W_LO;
  localparam int W_K   = 24;

  localparam logic signed [W_C-1:0] KINV_Q30 = 34'sd652032874;
  localparam logic [W_K-1:0]        KINV_Q24 = 24'd10188014;

  // transform registers
  typedef struct packed {
    logic signed [15:0] rot_xx;
    logic signed [15:0] rot_xy;
    logic signed [15:0] rot_yx;
    logic signed [15:0] rot_yy;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
  } xform_t;

  // one classified beam between front and back
  typedef struct packed {
    logic [15:0]           range_mm;
    logic [1:0]            quad;
    logic signed [W_Z-1:0] z;
  } beam_t;

  // arctangent of 2^-i in turns, 2^32 per turn
  function automatic logic signed [W_Z-1:0] atan_turns(input int i);
    logic signed [W_Z-1:0] v;
    case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lidar_beam_frame_transform.sv
// lidar_beam_frame_transform: top level, configuration registers and wiring
// depends on lbft_pkg, lbft_front, lbft_queue, lbft_back
//
// Usage:
//   in_* stream: one word per beam, in_tdata[15:0] range in mm,
//   in_tdata[27:16] beam index. out_* stream: out_tdata new range in mm,
//   out_tuser set when the distance was clipped to 65535.
//   cfg_* port: write register cfg_index with cfg_data, always ready;
//   write only while no beam is in flight.
// Throughput: one beam per cycle while the output is not held; the two
//   cordic chains are fully pipelined, one stage per iteration.
// Path: from input accept to output valid a beam passes the queue, the
//   rotation and vectoring chains (stage count capped at 24), the point,
//   coefficient and gain multiply stages, the transform sum and the
//   output register.
// Reset: rst_n clears the pipe, the queue and loads the identity
//   transform with zero angles.
// Stall: a held output word freezes the back pipe; the 4-entry queue
//   between the front and back keeps accepting until it fills, then
//   in_tready drops.
`default_nettype none
module lidar_beam_frame_transform #(
  parameter int MAX_BEAMS     = 4096,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // range_mm [15:0], beam_index [27:16], zero [31:28]
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // new_range_mm [15:0]
  output logic [15:0]      out_tdata,
  // saturated [0]
  output logic             out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import lbft_pkg::*;

  xform_t      xf_r;
  logic [15:0] start_r;
  logic [15:0] step_r;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xf_r.rot_xx  <= 16'sd16384;
      xf_r.rot_xy  <= '0;
      xf_r.rot_yx  <= '0;
      xf_r.rot_yy  <= 16'sd16384;
      xf_r.shift_x <= '0;
      xf_r.shift_y <= '0;
      start_r      <= '0;
      step_r       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROT_XX:  xf_r.rot_xx  <= cfg_data;
        REG_ROT_XY:  xf_r.rot_xy  <= cfg_data;
        REG_ROT_YX:  xf_r.rot_yx  <= cfg_data;
        REG_ROT_YY:  xf_r.rot_yy  <= cfg_data;
        REG_SHIFT_X: xf_r.shift_x <= cfg_data;
        REG_SHIFT_Y: xf_r.shift_y <= cfg_data;
        REG_START:   start_r      <= cfg_data;
        REG_STEP:    step_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: classify beam
  beam_t f_beam;
  lbft_front #(.MAX_BEAMS(MAX_BEAMS)) u_front (
    .range_mm    (in_tdata[15:0]),
    .beam_index  (in_tdata[27:16]),
    .start_angle (start_r),
    .angle_step  (step_r),
    .beam        (f_beam)
  );

  // queue between front and back
  beam_t q_data;
  logic  q_full, q_empty, q_pop;

  assign in_tready = !q_full;

  lbft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (f_beam),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // back: arithmetic pipe
  lbft_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .xf        (xf_r),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_range (out_tdata),
    .out_sat   (out_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

endmodule
`default_nettype wire

FILE: rtl/lbft_front.sv
// lbft_front: beam angle, quadrant reduction and cordic start angle
// depends on lbft_pkg
`default_nettype none
module lbft_front #(
  parameter int MAX_BEAMS = 4096
) (
  input  wire logic [15:0]   range_mm,
  input  wire logic [11:0]   beam_index,
  input  wire logic [15:0]   start_angle,
  input  wire logic [15:0]   angle_step,
  output lbft_pkg::beam_t    beam
);
  import lbft_pkg::*;

  localparam int          BCLAMP   = (MAX_BEAMS - 1 > 4095) ? 4095 : MAX_BEAMS - 1;
  localparam logic [11:0] BCLAMP_W = BCLAMP[11:0];
  localparam logic [16:0] BMAX_W   = MAX_BEAMS[16:0];

  logic [11:0]        beam_c;
  logic [27:0]        step_prod;
  logic [15:0]        angle;
  logic [15:0]        angle_q;
  logic [1:0]         quad;
  logic signed [15:0] resid;

  // clamp index, angle modulo one turn
  assign beam_c    = ({5'd0, beam_index} >= BMAX_W) ? BCLAMP_W : beam_index;
  assign step_prod = beam_c * angle_step;
  assign angle     = start_angle + step_prod[15:0];

  // nearest quadrant and residual within an eighth of a turn
  assign angle_q = angle + 16'd8192;
  assign quad    = angle_q[15:14];
  assign resid   = $signed(angle - {quad, 14'd0});

  assign beam.range_mm = range_mm;
  assign beam.quad     = quad;
  assign beam.z        = {{(W_Z-32){resid[15]}}, resid, 16'd0};

endmodule
`default_nettype wire

FILE: rtl/lbft_queue.sv
// lbft_queue: short first-in first-out queue of classified beams
// depends on lbft_pkg
`default_nettype none
module lbft_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  lbft_pkg::beam_t  push_data,
  output logic             full,
  input  wire logic        pop,
  output lbft_pkg::beam_t  pop_data,
  output logic             empty
);
  import lbft_pkg::*;

  beam_t      mem_r [4];
  logic [1:0] wptr_r, wptr_nxt;
  logic [1:0] rptr_r, rptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 3'd4);
  assign empty    = (cnt_r == 3'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  // pointer and fill count
  always_comb begin
    wptr_nxt = wptr_r + {1'b0, do_push};
    rptr_nxt = rptr_r + {1'b0, do_pop};
    cnt_nxt  = cnt_r + {2'd0, do_push} - {2'd0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lbft_back.sv
// lbft_back: sin/cos cordic, rigid transform, vectoring cordic and scaling
// depends on lbft_pkg; takes beams from lbft_queue
`default_nettype none
module lbft_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  lbft_pkg::xform_t   xf,
  input  lbft_pkg::beam_t    q_data,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic [15:0]        out_range,
  output logic               out_sat,
  output logic               out_valid,
  input  wire logic          out_ready
);
  import lbft_pkg::*;

  localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  // stages: NS rotation, point mult, coef mult, sum, NS vectoring, split mult
  localparam int NV = 2 * NS + 4;

  logic en;
  logic [NV-1:0] v_r;

  // whole pipe advances when the output word is free or being taken
  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NV-2:0], !q_empty};
    end
  end

  // rotation cordic
  logic signed [W_C-1:0] rx_r [NS+1];
  logic signed [W_C-1:0] ry_r [NS+1];
  logic signed [W_Z-1:0] rz_r [NS+1];
  logic [15:0]           rr_r [NS+1];
  logic [1:0]            rq_r [NS+1];

  always_comb begin
    rx_r[0] = KINV_Q30;
    ry_r[0] = '0;
    rz_r[0] = q_data.z;
    rr_r[0] = q_data.range_mm;
    rq_r[0] = q_data.quad;
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [W_C-1:0] xs, ys;
    assign xs = rx_r[i] >>> i;
    assign ys = ry_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rz_r[i] >= 0) begin
          rx_r[i+1] <= rx_r[i] - ys;
          ry_r[i+1] <= ry_r[i] + xs;
          rz_r[i+1] <= rz_r[i] - atan_turns(i);
        end else begin
          rx_r[i+1] <= rx_r[i] + ys;
          ry_r[i+1] <= ry_r[i] - xs;
          rz_r[i+1] <= rz_r[i] + atan_turns(i);
        end
        rr_r[i+1] <= rr_r[i];
        rq_r[i+1] <= rq_r[i];
      end
    end
  end

  // quadrant fix and range times cos/sin
  logic signed [W_C-1:0]  cs_c, sn_c;
  logic signed [W_PR-1:0] pcx_r, pcy_r;
  logic signed [16:0]     rng_s;

  always_comb begin
    case (rq_r[NS])
      2'd0: begin
        cs_c = rx_r[NS];  sn_c = ry_r[NS];
      end
      2'd1: begin
        cs_c = -ry_r[NS]; sn_c = rx_r[NS];
      end
      2'd2: begin
        cs_c = -rx_r[NS]; sn_c = -ry_r[NS];
      end
      default: begin
        cs_c = ry_r[NS];  sn_c = -rx_r[NS];
      end
    endcase
  end

  assign rng_s = $signed({1'b0, rr_r[NS]});

  always_ff @(posedge clk) begin
    if (en) begin
      pcx_r <= W_PR'(rng_s) * W_PR'(cs_c);
      pcy_r <= W_PR'(rng_s) * W_PR'(sn_c);
    end
  end

  // point in mm q16 times rotation coefficients
  logic signed [W_PT-1:0] px_c, py_c;
  logic signed [W_RP-1:0] mxx_r, mxy_r, myx_r, myy_r;
  logic signed [W_PR-15:0] pxs_c, pys_c;

  assign pxs_c = pcx_r[W_PR-1:14];
  assign pys_c = pcy_r[W_PR-1:14];
  assign px_c  = W_PT'(pxs_c);
  assign py_c  = W_PT'(pys_c);

  always_ff @(posedge clk) begin
    if (en) begin
      mxx_r <= W_RP'(xf.rot_xx) * W_RP'(px_c);
      mxy_r <= W_RP'(xf.rot_xy) * W_RP'(py_c);
      myx_r <= W_RP'(xf.rot_yx) * W_RP'(px_c);
      myy_r <= W_RP'(xf.rot_yy) * W_RP'(py_c);
    end
  end

  // transformed point plus translation, mm q30
  logic signed [W_V-1:0] tx_r, ty_r;
  logic signed [W_V-1:0] shx_c, shy_c;

  assign shx_c = {{(W_V-46){xf.shift_x[15]}}, xf.shift_x, 30'd0};
  assign shy_c = {{(W_V-46){xf.shift_y[15]}}, xf.shift_y, 30'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r <= W_V'(mxx_r) + W_V'(mxy_r) + shx_c;
      ty_r <= W_V'(myx_r) + W_V'(myy_r) + shy_c;
    end
  end

  // vectoring cordic on the folded vector
  logic signed [W_V-1:0] vx_r [NS+1];
  logic signed [W_V-1:0] vy_r [NS+1];

  always_comb begin
    vx_r[0] = (tx_r < 0) ? -tx_r : tx_r;
    vy_r[0] = ty_r;
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    logic signed [W_V-1:0] xs, ys;
    assign xs = vx_r[i] >>> i;
    assign ys = vy_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy_r[i] >= 0) begin
          vx_r[i+1] <= vx_r[i] + ys;
          vy_r[i+1] <= vy_r[i] - xs;
        end else begin
          vx_r[i+1] <= vx_r[i] - ys;
          vy_r[i+1] <= vy_r[i] + xs;
        end
      end
    end
  end

  // gain correction as two partial products
  logic signed [W_V-1:0]  vxc_c;
  logic [W_V-15:0]        mag_c;
  logic [W_M-1:0]         mag_m;
  logic [W_HI+W_K-1:0]    phi_r;
  logic [W_LO+W_K-1:0]    plo_r;

  assign vxc_c = (vx_r[NS] < 0) ? '0 : vx_r[NS];
  assign mag_c = vxc_c[W_V-1:14];
  assign mag_m = W_M'(mag_c);

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r <= mag_m[W_M-1:W_LO] * KINV_Q24;
      plo_r <= mag_m[W_LO-1:0] * KINV_Q24;
    end
  end

  // round to whole mm and saturate
  logic [W_HI+W_K+W_LO:0] sum_c;
  logic [W_HI+W_K+W_LO-40:0] dist_c;

  assign sum_c  = {1'b0, phi_r, {W_LO{1'b0}}} + (W_HI+W_K+W_LO+1)'(plo_r)
                  + ((W_HI+W_K+W_LO+1)'(1) << 39);
  assign dist_c = sum_c[W_HI+W_K+W_LO:40];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dist_c > (W_HI+W_K+W_LO-39)'(65535)) begin
        out_range <= 16'hFFFF;
        out_sat   <= 1'b1;
      end else begin
        out_range <= dist_c[15:0];
        out_sat   <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
